>>> design/lrukv_pkg.sv
package lrukv_pkg;

  // Default geometry
  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // Capacity register
  localparam int                 CAP_BITS  = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  // Result field widths
  localparam int STATUS_BITS = 3;
  localparam int OUT_BITS    = 32;

  // Operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_BITS-1:0] {
    ST_GET_HIT    = 3'd0,
    ST_GET_MISS   = 3'd1,
    ST_PUT_UPDATE = 3'd2,
    ST_PUT_INSERT = 3'd3,
    ST_PUT_EVICT  = 3'd4
  } status_t;

  // Write enables for the entry store
  typedef struct packed {
    logic key_we;
    logic val_we;
    logic rank_we;
  } store_we_t;

endpackage

>>> design/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement. Raise start
// with in_opcode, in_key and in_value while busy is low; the beat is taken at that edge
// and busy rises. A get miss ends after one search pass over the key and rank memories,
// one entry per cycle through a single compare unit; every other item takes one more pass
// over the rank memory to reorder. The result beat shows on out_strobe for one cycle right
// after busy falls, and a new item may start in that same cycle. The receiver cannot stall
// results: capture them when out_strobe is high. The capacity register is written through
// cfg_valid/cfg_data (cfg_ready is always high); the user must write it only while the
// block is idle, as the block does not enforce this. Zero acts as one and values above
// ENTRIES act as ENTRIES. No clearing pass is needed after reset.
module lru_key_value_cache #(
  parameter int ENTRIES    = lrukv_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = lrukv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lrukv_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_opcode,
  input  logic [KEY_BITS-1:0]               in_key,
  input  logic [VALUE_BITS-1:0]             in_value,
  output logic                              out_strobe,
  output logic [lrukv_pkg::STATUS_BITS-1:0] out_status,
  output logic [lrukv_pkg::OUT_BITS-1:0]    out_read_value,
  output logic [lrukv_pkg::OUT_BITS-1:0]    out_evicted_key,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lrukv_pkg::CAP_BITS-1:0]    cfg_data
);
  import lrukv_pkg::*;

  localparam int            IW       = $clog2(ENTRIES);
  localparam int            OCC_W    = $clog2(ENTRIES + 1);
  localparam int            CW       = (OCC_W > CAP_BITS) ? OCC_W : CAP_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [CW-1:0] CAP_MAX  = CW'(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_UPDATE,
    S_UPD_END
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CAP_BITS-1:0]     cap_r;
  logic [OCC_W-1:0]        occ_r;
  logic [ENTRIES-1:0]      valid_r;
  logic                    op_r;
  logic [KEY_BITS-1:0]     key_r;
  logic [VALUE_BITS-1:0]   val_r;
  logic [IW-1:0]           idx_r;
  logic                    cmp_vld_r;
  logic [IW-1:0]           cmp_idx_r;
  logic                    hit_fnd_r;
  logic [IW-1:0]           hit_idx_r;
  logic [IW-1:0]           hit_rank_r;
  logic [IW-1:0]           lru_idx_r;
  logic                    free_fnd_r;
  logic [IW-1:0]           free_idx_r;
  logic [IW-1:0]           slot_r;
  status_t                 status_r;
  logic                    promote_all_r;
  logic                    out_strobe_r;
  status_t                 out_status_r;
  logic [OUT_BITS-1:0]     out_read_value_r;
  logic [OUT_BITS-1:0]     out_evicted_key_r;

  store_we_t               st_we;
  logic [IW-1:0]           key_raddr;
  logic [IW-1:0]           rank_wdata;
  logic [KEY_BITS-1:0]     key_rdata;
  logic [VALUE_BITS-1:0]   val_rdata;
  logic [IW-1:0]           rank_rdata;

  logic                    accept;
  logic                    in_scan;
  logic                    in_sweep;
  logic                    entry_ok;
  logic                    key_eq;
  logic                    rank_is_lru;
  logic                    rank_younger;
  logic                    at_slot;
  logic [CW-1:0]           cap_eff;
  logic                    full;
  logic [IW-1:0]           slot_pick;
  status_t                 status_pick;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign in_scan  = cmp_vld_r && ((state_r == S_SCAN) || (state_r == S_SCAN_END));
  assign in_sweep = cmp_vld_r && ((state_r == S_UPDATE) || (state_r == S_UPD_END));

  // Shared compare unit on the entry that just came out of the memories
  assign entry_ok     = valid_r[cmp_idx_r];
  assign key_eq       = (key_rdata == key_r);
  assign rank_is_lru  = (OCC_W'(rank_rdata) == (occ_r - OCC_W'(1)));
  assign rank_younger = (rank_rdata < hit_rank_r);
  assign at_slot      = (cmp_idx_r == slot_r);

  // Effective capacity: clamp to 1 .. ENTRIES
  always_comb begin
    cap_eff = CW'(cap_r);
    if (cap_eff == '0) begin
      cap_eff = CW'(1);
    end else if (cap_eff > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end
  end

  assign full = (CW'(occ_r) >= cap_eff);

  // Pick target slot and status once the search is done
  always_comb begin
    if (op_r == OP_GET) begin
      slot_pick   = hit_idx_r;
      status_pick = hit_fnd_r ? ST_GET_HIT : ST_GET_MISS;
    end else if (hit_fnd_r) begin
      slot_pick   = hit_idx_r;
      status_pick = ST_PUT_UPDATE;
    end else if (full) begin
      slot_pick   = lru_idx_r;
      status_pick = ST_PUT_EVICT;
    end else begin
      slot_pick   = free_idx_r;
      status_pick = ST_PUT_INSERT;
    end
  end

  // Memory ports
  assign key_raddr  = (state_r == S_SCAN) ? idx_r : slot_r;
  assign rank_wdata = at_slot ? '0 : (rank_rdata + IW'(1));

  always_comb begin
    st_we.rank_we = in_sweep && (at_slot || (entry_ok && (promote_all_r || rank_younger)));
    st_we.val_we  = (state_r == S_UPD_END) && (op_r == OP_PUT);
    st_we.key_we  = (state_r == S_UPD_END) && (op_r == OP_PUT) && !hit_fnd_r;
  end

  lrukv_store #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk         (clk),
    .we          (st_we),
    .key_raddr   (key_raddr),
    .val_raddr   (hit_idx_r),
    .rank_raddr  (idx_r),
    .entry_waddr (slot_r),
    .rank_waddr  (cmp_idx_r),
    .key_wdata   (key_r),
    .val_wdata   (val_r),
    .rank_wdata  (rank_wdata),
    .key_rdata   (key_rdata),
    .val_rdata   (val_rdata),
    .rank_rdata  (rank_rdata)
  );

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (idx_r == LAST_IDX) state_nxt = S_SCAN_END;
      end
      S_SCAN_END: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = (status_pick == ST_GET_MISS) ? S_IDLE : S_UPDATE;
      end
      S_UPDATE: begin
        if (idx_r == LAST_IDX) state_nxt = S_UPD_END;
      end
      S_UPD_END: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, bookkeeping and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cap_r        <= CAP_RESET;
      occ_r        <= '0;
      valid_r      <= '0;
      cmp_vld_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= 1'b0;
      cmp_vld_r    <= (state_r == S_SCAN) || (state_r == S_UPDATE);
      cmp_idx_r    <= idx_r;

      if (cfg_valid) begin
        cap_r <= cfg_data;
      end

      // Latch the command beat and clear search results
      if (accept) begin
        op_r       <= in_opcode;
        key_r      <= in_key;
        val_r      <= in_value;
        idx_r      <= '0;
        hit_fnd_r  <= 1'b0;
        free_fnd_r <= 1'b0;
      end

      // Advance the entry counter through a pass
      if ((state_r == S_SCAN) || (state_r == S_UPDATE)) begin
        idx_r <= idx_r + IW'(1);
      end

      // Search: first matching key, least recent entry, lowest free slot
      if (in_scan) begin
        if (entry_ok && key_eq && !hit_fnd_r) begin
          hit_fnd_r  <= 1'b1;
          hit_idx_r  <= cmp_idx_r;
          hit_rank_r <= rank_rdata;
        end
        if (entry_ok && rank_is_lru) begin
          lru_idx_r <= cmp_idx_r;
        end
        if (!entry_ok && !free_fnd_r) begin
          free_fnd_r <= 1'b1;
          free_idx_r <= cmp_idx_r;
        end
      end

      // Decide slot and outcome; a miss reports at once
      if (state_r == S_DECIDE) begin
        slot_r        <= slot_pick;
        status_r      <= status_pick;
        promote_all_r <= !hit_fnd_r;
        idx_r         <= '0;
        if (status_pick == ST_GET_MISS) begin
          out_strobe_r      <= 1'b1;
          out_status_r      <= ST_GET_MISS;
          out_read_value_r  <= '0;
          out_evicted_key_r <= '0;
        end
      end

      // Finish: commit the entry and drive the result beat
      if (state_r == S_UPD_END) begin
        if (status_r == ST_PUT_INSERT || status_r == ST_PUT_EVICT) begin
          valid_r[slot_r] <= 1'b1;
        end
        if (status_r == ST_PUT_INSERT) begin
          occ_r <= occ_r + OCC_W'(1);
        end
        out_strobe_r      <= 1'b1;
        out_status_r      <= status_r;
        out_read_value_r  <= (status_r == ST_GET_HIT) ? OUT_BITS'(val_rdata) : '0;
        out_evicted_key_r <= (status_r == ST_PUT_EVICT) ? OUT_BITS'(key_rdata) : '0;
      end
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_value_r;
  assign out_evicted_key = out_evicted_key_r;

endmodule

>>> design/lrukv_store.sv
module lrukv_store #(
  parameter int ENTRIES    = lrukv_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = lrukv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lrukv_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk,
  input  lrukv_pkg::store_we_t       we,
  input  logic [$clog2(ENTRIES)-1:0] key_raddr,
  input  logic [$clog2(ENTRIES)-1:0] val_raddr,
  input  logic [$clog2(ENTRIES)-1:0] rank_raddr,
  input  logic [$clog2(ENTRIES)-1:0] entry_waddr,
  input  logic [$clog2(ENTRIES)-1:0] rank_waddr,
  input  logic [KEY_BITS-1:0]        key_wdata,
  input  logic [VALUE_BITS-1:0]      val_wdata,
  input  logic [$clog2(ENTRIES)-1:0] rank_wdata,
  output logic [KEY_BITS-1:0]        key_rdata,
  output logic [VALUE_BITS-1:0]      val_rdata,
  output logic [$clog2(ENTRIES)-1:0] rank_rdata
);
  import lrukv_pkg::*;

  localparam int IW = $clog2(ENTRIES);

  logic [KEY_BITS-1:0]   key_mem  [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem  [ENTRIES];
  logic [IW-1:0]         rank_mem [ENTRIES];

  // Key memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (we.key_we) begin
      key_mem[entry_waddr] <= key_wdata;
    end
    key_rdata <= key_mem[key_raddr];
  end

  // Value memory
  always_ff @(posedge clk) begin
    if (we.val_we) begin
      val_mem[entry_waddr] <= val_wdata;
    end
    val_rdata <= val_mem[val_raddr];
  end

  // Recency rank memory, swept read-modify-write
  always_ff @(posedge clk) begin
    if (we.rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    rank_rdata <= rank_mem[rank_raddr];
  end

endmodule

>>> design/lrukv_check.sv
module lrukv_check #(
  parameter int KEY_BITS   = lrukv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lrukv_pkg::VALUE_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              in_opcode,
  input logic [KEY_BITS-1:0]               in_key,
  input logic [VALUE_BITS-1:0]             in_value,
  input logic                              out_strobe,
  input logic [lrukv_pkg::STATUS_BITS-1:0] out_status,
  input logic [lrukv_pkg::OUT_BITS-1:0]    out_read_value,
  input logic [lrukv_pkg::OUT_BITS-1:0]    out_evicted_key,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [lrukv_pkg::CAP_BITS-1:0]    cfg_data
);
  import lrukv_pkg::*;

  // A command beat starts work
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after a command beat");

  // Work always ends in a result beat
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> busy || out_strobe)
    else $error("busy fell without a result beat");

  // A result beat only follows work
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result beat without preceding work");

  // Read value is zero except on a get hit
  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status != ST_GET_HIT) |-> out_read_value == '0)
    else $error("nonzero read value outside a get hit");

  // Evicted key is zero except on an eviction
  a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status != ST_PUT_EVICT) |-> out_evicted_key == '0)
    else $error("nonzero evicted key outside an eviction");

endmodule

bind lru_key_value_cache lrukv_check #(
  .KEY_BITS   (KEY_BITS),
  .VALUE_BITS (VALUE_BITS)
) u_lrukv_check (.*);

>>> verif/tb_lru_key_value_cache.sv
module tb_lru_key_value_cache;
  timeunit 1ns;
  timeprecision 1ps;

  import lrukv_pkg::*;

  localparam int SLOTS    = ENTRIES_DEF;
  localparam int BUSY_MAX = 2 * SLOTS + 3;

  typedef struct {
    status_t             status;
    logic [OUT_BITS-1:0] read_value;
    logic [OUT_BITS-1:0] evicted_key;
  } access_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_opcode;
  logic [KEY_BITS_DEF-1:0]   in_key;
  logic [VALUE_BITS_DEF-1:0] in_value;
  logic                      out_strobe;
  logic [STATUS_BITS-1:0]    out_status;
  logic [OUT_BITS-1:0]       out_read_value;
  logic [OUT_BITS-1:0]       out_evicted_key;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CAP_BITS-1:0]       cfg_data;

  // Shadow copy of the cache contents and LRU order
  logic [KEY_BITS_DEF-1:0]   slot_key  [SLOTS];
  logic [VALUE_BITS_DEF-1:0] slot_val  [SLOTS];
  bit                        slot_used [SLOTS];
  int unsigned               slot_age  [SLOTS];
  int unsigned               used_count;
  logic [CAP_BITS-1:0]       capacity_reg;

  access_result_t            pending_results[$];
  logic [KEY_BITS_DEF-1:0]   key_pool[$];
  int unsigned               error_count;
  int unsigned               sender_idle_pct;

  lru_key_value_cache uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_evicted_key (out_evicted_key),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Move slot s to the front; entries ahead of it age by one
  function automatic void make_recent(int s, bit was_used);
    int unsigned lim;
    lim = was_used ? slot_age[s] : SLOTS;
    for (int i = 0; i < SLOTS; i++)
      if (i != s && slot_used[i] && slot_age[i] < lim) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  // Apply one access to the shadow cache and return the result beat it yields
  function automatic access_result_t predict_access(logic op, logic [KEY_BITS_DEF-1:0] k,
                                                    logic [VALUE_BITS_DEF-1:0] v);
    access_result_t res;
    int unsigned    eff_cap;
    int unsigned    oldest;
    int             hit;
    int             slot;
    res.status      = ST_GET_MISS;
    res.read_value  = '0;
    res.evicted_key = '0;
    eff_cap = capacity_reg;
    if (eff_cap < 1) eff_cap = 1;
    if (eff_cap > SLOTS) eff_cap = SLOTS;
    hit = -1;
    for (int i = 0; i < SLOTS; i++)
      if (hit < 0 && slot_used[i] && slot_key[i] == k) hit = i;
    if (op == OP_GET) begin
      if (hit >= 0) begin
        res.status     = ST_GET_HIT;
        res.read_value = slot_val[hit];
        make_recent(hit, 1'b1);
      end
    end else if (hit >= 0) begin
      slot_val[hit] = v;
      make_recent(hit, 1'b1);
      res.status = ST_PUT_UPDATE;
    end else if (used_count >= eff_cap) begin
      // Replace the least recent entry; occupancy holds
      slot   = -1;
      oldest = 0;
      for (int i = 0; i < SLOTS; i++)
        if (slot_used[i] && (slot < 0 || slot_age[i] > oldest)) begin
          slot   = i;
          oldest = slot_age[i];
        end
      res.evicted_key = slot_key[slot];
      slot_key[slot]  = k;
      slot_val[slot]  = v;
      make_recent(slot, 1'b1);
      res.status = ST_PUT_EVICT;
    end else begin
      // Fill the lowest free slot
      slot = -1;
      for (int i = 0; i < SLOTS; i++)
        if (slot < 0 && !slot_used[i]) slot = i;
      slot_key[slot] = k;
      slot_val[slot] = v;
      make_recent(slot, 1'b0);
      slot_used[slot] = 1'b1;
      used_count++;
      res.status = ST_PUT_INSERT;
    end
    return res;
  endfunction

  // Send one access beat; leave start high so back-to-back beats need no toggle
  task automatic send_access(logic op, logic [KEY_BITS_DEF-1:0] k,
                             logic [VALUE_BITS_DEF-1:0] v);
    int gap;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(1, BUSY_MAX + 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_opcode <= op;
    in_key    <= k;
    in_value  <= v;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_access(op, k, v));
  endtask

  // Drop start and hold until every result beat is back
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_BITS-1:0] cap);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity_reg = cap;
  endtask

  // Get hit and miss, insert, update, all-zero and all-one keys and values
  task automatic test_basic_ops();
    send_access(OP_GET, 32'h0000_0000, 32'hDEAD_BEEF);
    send_access(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_access(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_access(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(OP_PUT, 32'h0000_0000, 32'h1234_5678);
    send_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
    // value is ignored on a get
    send_access(OP_GET, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
  endtask

  // Zero capacity, capacity below occupancy, capacity above the slot count
  task automatic test_capacity_limits();
    write_capacity(5'd0);
    send_access(OP_PUT, 32'h0000_00A5, 32'h0000_0001);
    send_access(OP_PUT, 32'h8000_0001, 32'h0000_0002);
    send_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_access(OP_PUT, 32'h8000_0001, 32'h0000_0003);
    write_capacity(5'd31);
    for (int i = 0; i < SLOTS - 1; i++)
      send_access(OP_PUT, 32'hC000_0000 | i, $urandom());
  endtask

  // Bursts over a small key pool so hits, updates and evictions dominate
  task automatic test_random_traffic(int n_items);
    int                      done;
    int                      burst;
    logic                    op;
    logic [KEY_BITS_DEF-1:0] k;
    logic [CAP_BITS-1:0]     cap;
    done = 0;
    while (done < n_items) begin
      case ($urandom_range(5))
        0:       cap = 5'd0;
        1:       cap = 5'd1;
        2:       cap = 5'd16;
        3:       cap = 5'd31;
        4:       cap = 5'd17;
        default: cap = CAP_BITS'($urandom_range(31));
      endcase
      write_capacity(cap);
      key_pool.delete();
      repeat ($urandom_range(2, 24)) key_pool.push_back($urandom());
      burst = $urandom_range(20, 60);
      repeat (burst) begin
        if ($urandom_range(99) < 85) k = key_pool[$urandom_range(key_pool.size() - 1)];
        else k = $urandom();
        op = 1'($urandom_range(1));
        send_access(op, k, $urandom());
        done++;
      end
    end
  endtask

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    access_result_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no access outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          error_count++;
        end
        if (out_read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, out_read_value);
          error_count++;
        end
        if (out_evicted_key !== want.evicted_key) begin
          $error("evicted_key: expected %h, got %h", want.evicted_key, out_evicted_key);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_opcode       = OP_GET;
    in_key          = '0;
    in_value        = '0;
    cfg_valid       = 1'b0;
    cfg_data        = CAP_RESET;
    error_count     = 0;
    sender_idle_pct = 0;
    used_count      = 0;
    capacity_reg    = CAP_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      slot_key[i]  = '0;
      slot_val[i]  = '0;
      slot_used[i] = 1'b0;
      slot_age[i]  = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_capacity_limits();
    sender_idle_pct = 28;
    test_random_traffic(300);
    sender_idle_pct = 60;
    test_random_traffic(300);
    sender_idle_pct = 0;
    test_random_traffic(300);

    // Drain, then allow a full access time for any stray beat
    wait_idle();
    repeat (BUSY_MAX + 5) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
